// ===== rtl/rbd_pkg.sv =====
// Shared command codes, dither threshold tables and channel helpers.
`default_nettype none

package rbd_pkg;

  localparam logic [2:0] CMD_BLEND        = 3'd0;
  localparam logic [2:0] CMD_BLEND_CH     = 3'd1;
  localparam logic [2:0] CMD_FADE         = 3'd2;
  localparam logic [2:0] CMD_BLEND_DITHER = 3'd3;
  localparam logic [2:0] CMD_DITHER       = 3'd4;
  localparam logic [2:0] CMD_MONO_DITHER  = 3'd5;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  // index is {row, column}
  localparam logic [3:0] THR_RED [64] = '{
    4'd1, 4'd7, 4'd3, 4'd5, 4'd0, 4'd8, 4'd2, 4'd6,
    4'd7, 4'd1, 4'd5, 4'd3, 4'd8, 4'd0, 4'd6, 4'd2,
    4'd3, 4'd5, 4'd0, 4'd8, 4'd2, 4'd6, 4'd1, 4'd7,
    4'd5, 4'd3, 4'd8, 4'd0, 4'd6, 4'd2, 4'd7, 4'd1,
    4'd0, 4'd8, 4'd2, 4'd6, 4'd1, 4'd7, 4'd3, 4'd5,
    4'd8, 4'd0, 4'd6, 4'd2, 4'd7, 4'd1, 4'd5, 4'd3,
    4'd2, 4'd6, 4'd1, 4'd7, 4'd3, 4'd5, 4'd0, 4'd8,
    4'd6, 4'd2, 4'd7, 4'd1, 4'd5, 4'd3, 4'd8, 4'd0
  };

  localparam logic [3:0] THR_GREEN [64] = '{
    4'd1, 4'd3, 4'd2, 4'd2, 4'd3, 4'd1, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd0, 4'd4, 4'd2, 4'd2, 4'd4, 4'd0,
    4'd3, 4'd1, 4'd2, 4'd2, 4'd1, 4'd3, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd4, 4'd0, 4'd2, 4'd2, 4'd0, 4'd4,
    4'd1, 4'd3, 4'd2, 4'd2, 4'd3, 4'd1, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd0, 4'd4, 4'd2, 4'd2, 4'd4, 4'd0,
    4'd3, 4'd1, 4'd2, 4'd2, 4'd1, 4'd3, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd4, 4'd0, 4'd2, 4'd2, 4'd0, 4'd4
  };

  localparam logic [3:0] THR_BLUE [64] = '{
    4'd5, 4'd3, 4'd8, 4'd0, 4'd6, 4'd2, 4'd7, 4'd1,
    4'd3, 4'd5, 4'd0, 4'd8, 4'd2, 4'd6, 4'd1, 4'd7,
    4'd8, 4'd0, 4'd6, 4'd2, 4'd7, 4'd1, 4'd5, 4'd3,
    4'd0, 4'd8, 4'd2, 4'd6, 4'd1, 4'd7, 4'd3, 4'd5,
    4'd6, 4'd2, 4'd7, 4'd1, 4'd5, 4'd3, 4'd8, 4'd0,
    4'd2, 4'd6, 4'd1, 4'd7, 4'd3, 4'd5, 4'd0, 4'd8,
    4'd7, 4'd1, 4'd5, 4'd3, 4'd8, 4'd0, 4'd6, 4'd2,
    4'd1, 4'd7, 4'd3, 4'd5, 4'd0, 4'd8, 4'd2, 4'd6
  };

  function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [3:0] t);
    logic [8:0] s;
    s = {1'b0, v} + {5'd0, t};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb565_blend_and_dither.sv =====
// Top level: RGB565 alpha blend, fade and 8x8 ordered dither compositor.
//
//  channel   signals                                   direction  handshake
//  request   start, busy, command, column, row,        in         start && !busy
//            bottom_pixel, top_pixel, alpha_red,
//            alpha_green, alpha_blue, color_rgb888
//  result    done, pixel_out                           out        done, one cycle
//
// One request per clock; busy stays low. Three register stages (input, blend,
// result) lie between the accepting edge and done. The blend stage
// holds one 9x9 multiplier per channel; the result stage does threshold add
// and saturation. rst clears the valid bits only. The receiver cannot stall.
`default_nettype none

module rgb565_blend_and_dither (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  column,
  input  logic [2:0]  row,
  input  logic [15:0] bottom_pixel,
  input  logic [15:0] top_pixel,
  input  logic [7:0]  alpha_red,
  input  logic [7:0]  alpha_green,
  input  logic [7:0]  alpha_blue,
  input  logic [23:0] color_rgb888,
  output logic        done,
  output logic [15:0] pixel_out
);

  import rbd_pkg::*;

  // input stage
  logic        in_valid;
  logic [2:0]  in_cmd;
  logic [5:0]  in_pos;
  logic [15:0] in_bot;
  logic [15:0] in_top;
  logic [7:0]  in_ar;
  logic [7:0]  in_ag;
  logic [7:0]  in_ab;
  logic [23:0] in_color;

  // blend stage
  logic        mid_valid;
  logic [2:0]  mid_cmd;
  logic [5:0]  mid_pos;
  logic [7:0]  mid_r;
  logic [7:0]  mid_g;
  logic [7:0]  mid_b;

  logic [7:0]  a_g;
  logic [7:0]  a_b;
  logic [15:0] bot_eff;
  logic [7:0]  bot_r, bot_g, bot_b;
  logic [7:0]  top_r, top_g, top_b;
  logic [7:0]  bl_r, bl_g, bl_b;
  logic        same;
  logic        all_full;
  logic        all_zero;
  logic        pick_top;
  logic        pick_bot;
  logic [7:0]  r_next, g_next, b_next;
  logic [15:0] dith_pixel;
  logic [15:0] pixel_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      in_cmd   <= command;
      in_pos   <= {row, column};
      in_bot   <= bottom_pixel;
      in_top   <= top_pixel;
      in_ar    <= alpha_red;
      in_ag    <= alpha_green;
      in_ab    <= alpha_blue;
      in_color <= color_rgb888;
    end
  end

  assign a_g     = (in_cmd == CMD_BLEND_CH) ? in_ag : in_ar;
  assign a_b     = (in_cmd == CMD_BLEND_CH) ? in_ab : in_ar;
  assign bot_eff = (in_cmd == CMD_FADE) ? 16'h0000 : in_bot;

  assign bot_r = {bot_eff[15:11], 3'b000};
  assign bot_g = {bot_eff[10:5], 2'b00};
  assign bot_b = {bot_eff[4:0], 3'b000};
  assign top_r = {in_top[15:11], 3'b000};
  assign top_g = {in_top[10:5], 2'b00};
  assign top_b = {in_top[4:0], 3'b000};

  rbd_blend u_blend_r (.bottom(bot_r), .top(top_r), .alpha(in_ar), .blended(bl_r));
  rbd_blend u_blend_g (.bottom(bot_g), .top(top_g), .alpha(a_g),   .blended(bl_g));
  rbd_blend u_blend_b (.bottom(bot_b), .top(top_b), .alpha(a_b),   .blended(bl_b));

  assign same     = (in_top == in_bot);
  assign all_full = (in_ar == ALPHA_FULL) && (in_ag == ALPHA_FULL) && (in_ab == ALPHA_FULL);
  assign all_zero = (in_ar == 8'h00) && (in_ag == 8'h00) && (in_ab == 8'h00);

  always_comb begin
    pick_top = 1'b0;
    pick_bot = 1'b0;
    case (in_cmd)
      CMD_BLEND, CMD_BLEND_DITHER: begin
        pick_top = same || (in_ar == ALPHA_FULL);
        pick_bot = (in_ar == 8'h00);
      end
      CMD_BLEND_CH: begin
        pick_top = same || all_full;
        pick_bot = all_zero;
      end
      CMD_FADE: begin
        pick_top = (in_ar == ALPHA_FULL);
        pick_bot = (in_ar == 8'h00);
      end
      default: begin
        pick_top = 1'b0;
        pick_bot = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (in_cmd == CMD_DITHER || in_cmd == CMD_MONO_DITHER) begin
      r_next = in_color[23:16];
      g_next = in_color[15:8];
      b_next = in_color[7:0];
    end else if (pick_top) begin
      r_next = top_r;
      g_next = top_g;
      b_next = top_b;
    end else if (pick_bot) begin
      r_next = bot_r;
      g_next = bot_g;
      b_next = bot_b;
    end else begin
      r_next = bl_r;
      g_next = bl_g;
      b_next = bl_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
    mid_cmd <= in_cmd;
    mid_pos <= in_pos;
    mid_r   <= r_next;
    mid_g   <= g_next;
    mid_b   <= b_next;
  end

  rbd_dither u_dither (
    .pos   (mid_pos),
    .mono  (mid_cmd == CMD_MONO_DITHER),
    .red   (mid_r),
    .green (mid_g),
    .blue  (mid_b),
    .pixel (dith_pixel)
  );

  always_comb begin
    case (mid_cmd)
      CMD_BLEND, CMD_BLEND_CH, CMD_FADE: pixel_next = pack565(mid_r, mid_g, mid_b);
      CMD_BLEND_DITHER, CMD_DITHER, CMD_MONO_DITHER: pixel_next = dith_pixel;
      default: pixel_next = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid_valid;
    end
    pixel_out <= pixel_next;
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##3 done)
    else $error("request did not complete in three cycles");

  a_unused_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && (command[2:1] == 2'b11)) |-> ##3 (pixel_out == 16'h0000))
    else $error("unused command gave a nonzero pixel");

  a_equal_pixels: assert property (@(posedge clk) disable iff (rst)
    (start && (command == CMD_BLEND) && (top_pixel == bottom_pixel))
      |-> ##3 (pixel_out == $past(top_pixel, 3)))
    else $error("blend of equal pixels changed the pixel");

  a_fade_zero: assert property (@(posedge clk) disable iff (rst)
    (start && (command == CMD_FADE) && (alpha_red == 8'h00))
      |-> ##3 (pixel_out == 16'h0000))
    else $error("fade with zero alpha is not black");
`endif

endmodule

`default_nettype wire

// ===== rtl/rbd_blend.sv =====
// One channel of the alpha blend: bottom*(256-a) + top*a, upper byte kept.
`default_nettype none

module rbd_blend (
  input  logic [7:0] bottom,
  input  logic [7:0] top,
  input  logic [7:0] alpha,
  output logic [7:0] blended
);

  logic signed [8:0]  diff;
  logic signed [8:0]  alpha_s;
  logic signed [17:0] prod;
  logic signed [17:0] sum;

  assign diff    = $signed({1'b0, top}) - $signed({1'b0, bottom});
  assign alpha_s = $signed({1'b0, alpha});
  assign prod    = diff * alpha_s;
  assign sum     = $signed({2'b00, bottom, 8'h00}) + prod;
  assign blended = sum[15:8];

endmodule

`default_nettype wire

// ===== rtl/rbd_dither.sv =====
// Ordered 8x8 dither of three 8-bit channels to one RGB565 pixel.
`default_nettype none

module rbd_dither (
  input  logic [5:0]  pos,
  input  logic        mono,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic [15:0] pixel
);

  import rbd_pkg::*;

  logic [3:0] t_red;
  logic [3:0] t_green;
  logic [3:0] t_blue;
  logic [3:0] t_mono2;

  assign t_mono2 = {THR_GREEN[pos][2:0], 1'b0};
  assign t_green = THR_GREEN[pos];
  assign t_red   = mono ? t_mono2 : THR_RED[pos];
  assign t_blue  = mono ? t_mono2 : THR_BLUE[pos];

  assign pixel = pack565(sat_add(red, t_red), sat_add(green, t_green),
                         sat_add(blue, t_blue));

endmodule

`default_nettype wire
